// ===== sv/dhms_pkg.sv =====
// Shared types, widths and codes of the delta header message splitter.
package dhms_pkg;

  // Field widths fixed by the item formats.
  localparam int BYTE_W   = 8;
  localparam int SIZE_W   = 16;
  localparam int OFFSET_W = 16;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 3;

  // Default width of the running byte position.
  localparam int POSITION_BITS_DEF = 16;

  // Reset value of the message limit register.
  localparam logic [COUNT_W-1:0] MAX_MSG_RESET = COUNT_W'(64);

  // Largest value the message counter can hold; it saturates there.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Header bits that must be clear in a valid header byte.
  localparam logic [BYTE_W-1:0] HEADER_RESERVED = 8'hF0;

  // End status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HEADER_CUT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PAYLOAD_CUT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIMIT       = 3'd5;

  // One result item.
  typedef struct packed {
    logic                message_valid;
    logic [OFFSET_W-1:0] payload_offset;
    logic [SIZE_W-1:0]   payload_length;
    logic [BYTE_W-1:0]   protocol_id;
    logic [BYTE_W-1:0]   message_flags;
    logic                buffer_end;
    logic [STATUS_W-1:0] end_status;
    logic [COUNT_W-1:0]  message_count;
  } result_t;

endpackage

// ===== sv/dhms_if.sv =====
// Valid/ready channel interfaces for the input bytes and the result items.
interface dhms_in_if;
  logic                          valid;
  logic                          ready;
  logic [dhms_pkg::BYTE_W-1:0]   data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dhms_out_if;
  logic                          valid;
  logic                          ready;
  logic                          message_valid;
  logic [dhms_pkg::OFFSET_W-1:0] payload_offset;
  logic [dhms_pkg::SIZE_W-1:0]   payload_length;
  logic [dhms_pkg::BYTE_W-1:0]   protocol_id;
  logic [dhms_pkg::BYTE_W-1:0]   message_flags;
  logic                          buffer_end;
  logic [dhms_pkg::STATUS_W-1:0] end_status;
  logic [dhms_pkg::COUNT_W-1:0]  message_count;

  modport source (output valid, output message_valid, output payload_offset,
                  output payload_length, output protocol_id, output message_flags,
                  output buffer_end, output end_status, output message_count,
                  input ready);
  modport sink   (input valid, input message_valid, input payload_offset,
                  input payload_length, input protocol_id, input message_flags,
                  input buffer_end, input end_status, input message_count,
                  output ready);
endinterface

// ===== sv/dhms_parser.sv =====
// Header and payload parser: per-buffer state, one byte per step.
module dhms_parser #(
  parameter int POSITION_BITS = dhms_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [dhms_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         last_byte,
  input  logic                         cfg_we,
  input  logic [dhms_pkg::COUNT_W-1:0] cfg_data,
  output logic                         res_valid,
  output dhms_pkg::result_t            res
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_FLAGS, PH_SIZE_HI, PH_SIZE_LO, PH_PROTO, PH_SKIP, PH_PAYLOAD, PH_STOP
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [3:0]                      pending_r, pending_nxt;
  logic [dhms_pkg::BYTE_W-1:0]     flags_r, flags_nxt;
  logic [dhms_pkg::SIZE_W-1:0]     size_r, size_nxt;
  logic                            size_known_r, size_known_nxt;
  logic [dhms_pkg::BYTE_W-1:0]     proto_r, proto_nxt;
  logic                            proto_known_r, proto_known_nxt;
  logic [POSITION_BITS-1:0]        pos_r, pos_nxt;
  logic [dhms_pkg::SIZE_W-1:0]     left_r, left_nxt;
  logic [POSITION_BITS-1:0]        start_r, start_nxt;
  logic [dhms_pkg::COUNT_W-1:0]    seen_r, seen_nxt;
  logic [dhms_pkg::STATUS_W-1:0]   stop_r, stop_nxt;
  logic [dhms_pkg::COUNT_W-1:0]    max_r;

  logic                            done;
  logic                            do_adv;
  logic                            halt;
  logic [dhms_pkg::STATUS_W-1:0]   halt_code;
  logic [3:0]                      pend_tmp;

  // Next state and result for the byte at hand.
  always_comb begin
    phase_nxt       = phase_r;
    pending_nxt     = pending_r;
    flags_nxt       = flags_r;
    size_nxt        = size_r;
    size_known_nxt  = size_known_r;
    proto_nxt       = proto_r;
    proto_known_nxt = proto_known_r;
    pos_nxt         = pos_r;
    left_nxt        = left_r;
    start_nxt       = start_r;
    seen_nxt        = seen_r;
    stop_nxt        = stop_r;
    done            = 1'b0;
    do_adv          = 1'b0;
    halt            = 1'b0;
    halt_code       = dhms_pkg::ST_OK;
    pend_tmp        = pending_r;

    // Consume the byte according to the current phase.
    case (phase_r)
      PH_HEADER: begin
        if (seen_r >= max_r) begin
          halt      = 1'b1;
          halt_code = dhms_pkg::ST_LIMIT;
        end else if ((data_byte & dhms_pkg::HEADER_RESERVED) != '0 ||
                     (data_byte == '0 && !size_known_r)) begin
          halt      = 1'b1;
          halt_code = dhms_pkg::ST_BAD_HEADER;
        end else begin
          pend_tmp = data_byte[3:0];
          do_adv   = 1'b1;
        end
      end
      PH_FLAGS: begin
        flags_nxt = data_byte;
        pend_tmp  = pending_r & 4'b1110;
        do_adv    = 1'b1;
      end
      PH_SIZE_HI: begin
        size_nxt  = {data_byte, 8'h00};
        phase_nxt = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        size_nxt       = {size_r[15:8], data_byte};
        size_known_nxt = 1'b1;
        pend_tmp       = pending_r & 4'b1101;
        do_adv         = 1'b1;
      end
      PH_PROTO: begin
        proto_nxt       = data_byte;
        proto_known_nxt = 1'b1;
        pend_tmp        = pending_r & 4'b1011;
        do_adv          = 1'b1;
      end
      PH_SKIP: begin
        pend_tmp = pending_r & 4'b0111;
        do_adv   = 1'b1;
      end
      PH_PAYLOAD: begin
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          phase_nxt = PH_HEADER;
          done      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Go to the next announced field, or close the header.
    if (do_adv) begin
      pending_nxt = pend_tmp;
      if (pend_tmp[0]) begin
        phase_nxt = PH_FLAGS;
      end else if (pend_tmp[1]) begin
        phase_nxt = PH_SIZE_HI;
      end else if (pend_tmp[2]) begin
        phase_nxt = PH_PROTO;
      end else if (pend_tmp[3]) begin
        phase_nxt = PH_SKIP;
      end else if (!size_known_nxt || !proto_known_nxt) begin
        halt      = 1'b1;
        halt_code = dhms_pkg::ST_UNKNOWN;
      end else begin
        start_nxt = pos_r + 1'b1;
        if (size_nxt == '0) begin
          phase_nxt = PH_HEADER;
          done      = 1'b1;
        end else begin
          left_nxt  = size_nxt;
          phase_nxt = PH_PAYLOAD;
        end
      end
    end

    // Stop parsing for the rest of the buffer.
    if (halt) begin
      phase_nxt   = PH_STOP;
      stop_nxt    = halt_code;
      pending_nxt = '0;
    end

    if (done && seen_r != dhms_pkg::COUNT_MAX) begin
      seen_nxt = seen_r + 1'b1;
    end

    // Build the result item.
    res_valid          = step && (done || last_byte);
    res                = '0;
    res.message_valid  = done;
    res.message_count  = seen_nxt;
    if (done) begin
      res.payload_offset = dhms_pkg::OFFSET_W'(start_nxt);
      res.payload_length = size_nxt;
      res.protocol_id    = proto_nxt;
      res.message_flags  = flags_nxt;
    end
    if (last_byte) begin
      res.buffer_end = 1'b1;
      case (phase_nxt)
        PH_STOP:    res.end_status = stop_nxt;
        PH_HEADER:  res.end_status = dhms_pkg::ST_OK;
        PH_PAYLOAD: res.end_status = dhms_pkg::ST_PAYLOAD_CUT;
        default:    res.end_status = dhms_pkg::ST_HEADER_CUT;
      endcase
    end

    // The last byte restarts all per-buffer state.
    if (last_byte) begin
      phase_nxt       = PH_HEADER;
      pending_nxt     = '0;
      flags_nxt       = '0;
      size_nxt        = '0;
      size_known_nxt  = 1'b0;
      proto_nxt       = '0;
      proto_known_nxt = 1'b0;
      pos_nxt         = '0;
      left_nxt        = '0;
      start_nxt       = '0;
      seen_nxt        = '0;
      stop_nxt        = dhms_pkg::ST_OK;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  // Parser state and the message limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      pending_r     <= '0;
      flags_r       <= '0;
      size_r        <= '0;
      size_known_r  <= 1'b0;
      proto_r       <= '0;
      proto_known_r <= 1'b0;
      pos_r         <= '0;
      left_r        <= '0;
      start_r       <= '0;
      seen_r        <= '0;
      stop_r        <= dhms_pkg::ST_OK;
      max_r         <= dhms_pkg::MAX_MSG_RESET;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      if (step) begin
        phase_r       <= phase_nxt;
        pending_r     <= pending_nxt;
        flags_r       <= flags_nxt;
        size_r        <= size_nxt;
        size_known_r  <= size_known_nxt;
        proto_r       <= proto_nxt;
        proto_known_r <= proto_known_nxt;
        pos_r         <= pos_nxt;
        left_r        <= left_nxt;
        start_r       <= start_nxt;
        seen_r        <= seen_nxt;
        stop_r        <= stop_nxt;
      end
    end
  end

endmodule

// ===== sv/delta_header_message_splitter_top.sv =====
// Top level: input register, parser and a two-entry result buffer.
// A byte waits in the input register; its result item is registered in the head or skid entry.
// Throughput: one byte per cycle with skid free; input register and skid entry decouple stalls.
// Synchronous active-low reset clears the parser state and the buffer and sets the limit to 64.
// The message limit register keeps its value across buffer ends.
module delta_header_message_splitter_top #(
  parameter int POSITION_BITS = dhms_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  dhms_in_if.sink                      in_ch,
  dhms_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [dhms_pkg::COUNT_W-1:0] cfg_data
);

  logic                        in_valid_r;
  logic [dhms_pkg::BYTE_W-1:0] in_byte_r;
  logic                        in_last_r;
  logic                        in_accept;
  logic                        proc;

  logic                        res_valid;
  dhms_pkg::result_t           res;

  logic                        head_valid_r, head_valid_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  dhms_pkg::result_t           head_r, head_nxt;
  dhms_pkg::result_t           skid_r, skid_nxt;
  logic                        pop;

  // Input register: a byte is processed when the skid entry is free.
  assign proc         = in_valid_r && !skid_valid_r;
  assign in_ch.ready  = !in_valid_r || proc;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  dhms_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // Two-entry result buffer: head drives the port, skid catches a stalled push.
  assign pop = head_valid_r && out_ch.ready;

  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        head_valid_nxt = 1'b1;
        skid_valid_nxt = res_valid;
        skid_nxt       = res;
      end else begin
        head_valid_nxt = res_valid;
        head_nxt       = res;
      end
    end else if (!head_valid_r) begin
      head_valid_nxt = res_valid;
      head_nxt       = res;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  // Output port.
  assign out_ch.valid          = head_valid_r;
  assign out_ch.message_valid  = head_r.message_valid;
  assign out_ch.payload_offset = head_r.payload_offset;
  assign out_ch.payload_length = head_r.payload_length;
  assign out_ch.protocol_id    = head_r.protocol_id;
  assign out_ch.message_flags  = head_r.message_flags;
  assign out_ch.buffer_end     = head_r.buffer_end;
  assign out_ch.end_status     = head_r.end_status;
  assign out_ch.message_count  = head_r.message_count;

  // The skid entry only fills behind an occupied head.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> head_valid_r)
    else $error("skid entry holds an item while the head is empty");

  // A processed byte never finds the buffer full.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && head_valid_r && !pop) |-> !skid_valid_r)
    else $error("result buffer overflow");

  // An end status is only given with the buffer end.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.buffer_end) |-> (out_ch.end_status == dhms_pkg::ST_OK))
    else $error("end status given without buffer end");

  // Descriptor fields are zero when no message is carried.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.message_valid) |->
      (out_ch.payload_length == '0 && out_ch.payload_offset == '0 &&
       out_ch.protocol_id == '0 && out_ch.message_flags == '0))
    else $error("descriptor fields set without a message");

endmodule
